// ----- design/pwcc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pinned write-back counter cache.
// Holds command and status codes and the command, result and entry word types.
package pwcc_pkg;

  localparam logic [2:0] CMD_PREPARE   = 3'd0;
  localparam logic [2:0] CMD_COMMIT    = 3'd1;
  localparam logic [2:0] CMD_ABORT     = 3'd2;
  localparam logic [2:0] CMD_SYNC      = 3'd3;
  localparam logic [2:0] CMD_OVERLAY   = 3'd4;
  localparam logic [2:0] CMD_FLUSH     = 3'd5;
  localparam logic [2:0] CMD_FLUSHDROP = 3'd6;
  localparam logic [2:0] CMD_DRAIN     = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic KIND_RESP  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key_id;
    logic [63:0] seed_value;
    logic [63:0] now_stamp;
    logic [63:0] mtime_in;
    logic [63:0] ctime_in;
    logic        persist_ok;
  } cmd_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [63:0] flush_id;
    logic [63:0] flush_delta;
    logic [63:0] count_before;
    logic [63:0] count_after;
    logic [63:0] mtime_out;
    logic [63:0] ctime_out;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [63:0] logical;
    logic [63:0] pending;
    logic [63:0] stamp;
  } entry_word_t;

endpackage

// ----- design/pinned_writeback_counter_cache.sv -----
`timescale 1ns / 1ps
// Pinned write-back counter cache: associative id table with one entry memory.
// Depends on pwcc_pkg for codes and word types.
//
// Flow: a lookup, then execution on a hit or a room check on a prepare miss;
// any other miss responds from the lookup. A flush request word, when sent,
// precedes the final response. A prepare miss on a full table evicts clean
// unpinned entries first, then writes back the least recent unpinned dirty victim.
// Drain writes back every dirty entry, least recent first. One command at a time;
// busy stays high until the last word.
// Reset: table empty, capacity 32; no clearing pass. Results cannot be stalled.
module pinned_writeback_counter_cache
  import pwcc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_word_t  cmd_i,
  output logic       res_valid_o,
  output res_word_t  res_o,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);

  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_EXE  = 4'd2;
  localparam logic [3:0] S_PCHK = 4'd3;
  localparam logic [3:0] S_PLRU = 4'd4;
  localparam logic [3:0] S_PEV  = 4'd5;
  localparam logic [3:0] S_DSEL = 4'd6;
  localparam logic [3:0] S_DEX  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  // Control state
  logic [3:0]    state_q, state_d;
  cmd_word_t     cur_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] vic_q, vic_d;
  logic [CW-1:0] r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          fail_q, fail_d;
  logic [1:0]    st_q, st_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic [5:0]    cap_q;
  logic          rv_q, rv_d;
  res_word_t     res_q, res_d;

  // Per-entry flags and metadata
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] dirty_q, dirty_d;
  logic [15:0]   pin_q  [TABLE_ENTRIES];
  logic [15:0]   pin_d  [TABLE_ENTRIES];
  logic [IW-1:0] rank_q [TABLE_ENTRIES];
  logic [IW-1:0] rank_d [TABLE_ENTRIES];
  logic [63:0]   key_q  [TABLE_ENTRIES];

  // Entry memory: counter, pending delta and stamp
  entry_word_t   mem_q [TABLE_ENTRIES];
  entry_word_t   rd_q;
  entry_word_t   wdata;
  logic [IW-1:0] raddr;
  logic          mem_we;

  // Actions on the target entry in this cycle
  logic [IW-1:0] tgt;
  logic rk_clean, rk_mru, pin_inc, pin_dec, pin_set1;
  logic v_set, v_clr, key_we, used_inc, used_dec;

  // Search vectors
  logic [TABLE_ENTRIES-1:0] hit_vec, cln_vec, free_vec, r0_vec, rr_vec;
  logic [IW-1:0] hit_idx, cln_idx, free_idx, r0_idx, rr_idx;
  logic [CMPW-1:0] cap_eff;
  logic [15:0]   pin_new;
  logic [IW-1:0] old_rank;

  function automatic logic [IW-1:0] first_idx(input logic [TABLE_ENTRIES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (v[k]) r = IW'(k);
    end
    return r;
  endfunction

  function automatic res_word_t mk_resp(input logic [1:0] status);
    res_word_t w;
    w = '0;
    w.kind   = KIND_RESP;
    w.status = status;
    w.last   = 1'b1;
    return w;
  endfunction

  function automatic res_word_t mk_flush(input logic ok, input logic [63:0] id,
                                         input logic [63:0] delta);
    res_word_t w;
    w = '0;
    w.kind        = KIND_FLUSH;
    w.status      = ok ? ST_OK : ST_FAIL;
    w.flush_id    = id;
    w.flush_delta = delta;
    return w;
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // Clamp the capacity register into the legal range
  always_comb begin
    cap_eff = CMPW'(cap_q);
    if (cap_eff < CMPW'(4)) cap_eff = CMPW'(4);
    if (cap_eff > CMPW'(TABLE_ENTRIES)) cap_eff = CMPW'(TABLE_ENTRIES);
  end

  // Per-entry match lines
  always_comb begin
    for (int j = 0; j < TABLE_ENTRIES; j++) begin
      hit_vec[j]  = valid_q[j] && (key_q[j] == cur_q.key_id);
      cln_vec[j]  = valid_q[j] && !dirty_q[j] && (pin_q[j] == '0);
      free_vec[j] = !valid_q[j];
      r0_vec[j]   = dirty_q[j] && (rank_q[j] == '0);
      rr_vec[j]   = dirty_q[j] && (CW'(rank_q[j]) == r_q);
    end
  end

  assign hit_idx  = first_idx(hit_vec);
  assign cln_idx  = first_idx(cln_vec);
  assign free_idx = first_idx(free_vec);
  assign r0_idx   = first_idx(r0_vec);
  assign rr_idx   = first_idx(rr_vec);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    vic_d    = vic_q;
    r_d      = r_q;
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    st_d     = st_q;
    rv_d     = 1'b0;
    res_d    = res_q;
    tgt      = idx_q;
    raddr    = idx_q;
    mem_we   = 1'b0;
    wdata    = rd_q;
    rk_clean = 1'b0;
    rk_mru   = 1'b0;
    pin_inc  = 1'b0;
    pin_dec  = 1'b0;
    pin_set1 = 1'b0;
    v_set    = 1'b0;
    v_clr    = 1'b0;
    key_we   = 1'b0;
    used_inc = 1'b0;
    used_dec = 1'b0;
    pin_new  = (pin_q[idx_q] != '0) ? pin_q[idx_q] - 16'd1 : '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_LOOK;
      end

      S_LOOK: begin
        // Look up the id and start the entry read in the same cycle
        raddr = hit_idx;
        idx_d = hit_idx;
        if (cur_q.cmd == CMD_DRAIN) begin
          cnt_d   = dcnt_q;
          fail_d  = 1'b0;
          state_d = S_DSEL;
        end else if (|hit_vec) begin
          state_d = S_EXE;
        end else if (cur_q.cmd == CMD_PREPARE) begin
          state_d = S_PCHK;
        end else begin
          rv_d    = 1'b1;
          state_d = S_IDLE;
          case (cur_q.cmd)
            CMD_FLUSHDROP: res_d = mk_resp(ST_OK);
            CMD_OVERLAY: begin
              res_d             = mk_resp(ST_MISS);
              res_d.count_after = cur_q.seed_value;
              res_d.mtime_out   = cur_q.mtime_in;
              res_d.ctime_out   = cur_q.ctime_in;
            end
            default: res_d = mk_resp(ST_MISS);
          endcase
        end
      end

      S_EXE: begin
        rv_d    = 1'b1;
        res_d   = mk_resp(ST_OK);
        state_d = S_IDLE;
        case (cur_q.cmd)
          CMD_PREPARE: begin
            mem_we  = 1'b1;
            if (cur_q.seed_value > rd_q.logical) wdata.logical = cur_q.seed_value;
            pin_inc = 1'b1;
          end
          CMD_COMMIT: begin
            mem_we        = 1'b1;
            wdata.logical = rd_q.logical + 64'd1;
            wdata.pending = rd_q.pending + 64'd1;
            if (cur_q.now_stamp > rd_q.stamp) wdata.stamp = cur_q.now_stamp;
            rk_mru  = 1'b1;
            pin_dec = 1'b1;
            res_d.count_before = rd_q.logical;
            res_d.count_after  = rd_q.logical + 64'd1;
          end
          CMD_ABORT: begin
            pin_dec = 1'b1;
            if (pin_new == '0 && !dirty_q[idx_q] && rd_q.pending == '0) begin
              v_clr    = 1'b1;
              used_dec = 1'b1;
            end
          end
          CMD_SYNC: begin
            mem_we        = 1'b1;
            wdata.logical = rd_q.logical + 64'd1;
            if (cur_q.now_stamp > rd_q.stamp) wdata.stamp = cur_q.now_stamp;
          end
          CMD_OVERLAY: begin
            res_d.count_after = (rd_q.logical > cur_q.seed_value) ?
                                rd_q.logical : cur_q.seed_value;
            res_d.mtime_out   = (rd_q.stamp > cur_q.mtime_in) ? rd_q.stamp : cur_q.mtime_in;
            res_d.ctime_out   = (rd_q.stamp > cur_q.ctime_in) ? rd_q.stamp : cur_q.ctime_in;
          end
          default: begin
            // Single-entry flush, optionally dropping the entry
            if (!dirty_q[idx_q] || rd_q.pending == '0) begin
              if (cur_q.cmd == CMD_FLUSHDROP && pin_q[idx_q] == '0 &&
                  rd_q.pending == '0) begin
                rk_clean = 1'b1;
                v_clr    = 1'b1;
                used_dec = 1'b1;
              end
            end else begin
              res_d   = mk_flush(cur_q.persist_ok, cur_q.key_id, rd_q.pending);
              state_d = S_RESP;
              if (cur_q.persist_ok) begin
                mem_we        = 1'b1;
                wdata.pending = '0;
                rk_clean      = 1'b1;
                st_d          = ST_OK;
                if (cur_q.cmd == CMD_FLUSHDROP && pin_q[idx_q] == '0) begin
                  v_clr    = 1'b1;
                  used_dec = 1'b1;
                end
              end else begin
                // Refused: keep the delta and move to most recent
                rk_mru = 1'b1;
                st_d   = ST_FAIL;
              end
            end
          end
        endcase
      end

      S_PCHK: begin
        if (CMPW'(used_q) >= cap_eff) begin
          if (|cln_vec) begin
            // Drop a clean unpinned entry, no word out
            tgt      = cln_idx;
            v_clr    = 1'b1;
            used_dec = 1'b1;
          end else begin
            r_d     = '0;
            state_d = S_PLRU;
          end
        end else begin
          rv_d    = 1'b1;
          state_d = S_IDLE;
          if (|free_vec) begin
            tgt           = free_idx;
            v_set         = 1'b1;
            key_we        = 1'b1;
            mem_we        = 1'b1;
            wdata.logical = cur_q.seed_value;
            wdata.pending = '0;
            wdata.stamp   = '0;
            pin_set1      = 1'b1;
            used_inc      = 1'b1;
            res_d         = mk_resp(ST_OK);
          end else begin
            res_d = mk_resp(ST_FAIL);
          end
        end
      end

      S_PLRU: begin
        // Walk ranks from least recent for an unpinned dirty victim
        if (r_q >= dcnt_q) begin
          rv_d    = 1'b1;
          res_d   = mk_resp(ST_FAIL);
          state_d = S_IDLE;
        end else if ((|rr_vec) && pin_q[rr_idx] == '0) begin
          vic_d   = rr_idx;
          raddr   = rr_idx;
          state_d = S_PEV;
        end else begin
          r_d = r_q + CW'(1);
        end
      end

      S_PEV: begin
        tgt = vic_q;
        if (rd_q.pending != '0) begin
          rv_d  = 1'b1;
          res_d = mk_flush(cur_q.persist_ok, key_q[vic_q], rd_q.pending);
        end
        if (cur_q.persist_ok || rd_q.pending == '0) begin
          rk_clean = 1'b1;
          v_clr    = 1'b1;
          used_dec = 1'b1;
          state_d  = S_PCHK;
        end else begin
          // Refused: the victim stays, now most recent
          rk_mru  = 1'b1;
          st_d    = ST_FAIL;
          state_d = S_RESP;
        end
      end

      S_DSEL: begin
        if (cnt_q == '0) begin
          rv_d    = 1'b1;
          res_d   = mk_resp(fail_q ? ST_FAIL : ST_OK);
          state_d = S_IDLE;
        end else begin
          vic_d   = r0_idx;
          raddr   = r0_idx;
          state_d = S_DEX;
        end
      end

      S_DEX: begin
        // Always take the least recent; refused ones rotate to the back
        tgt     = vic_q;
        rv_d    = 1'b1;
        res_d   = mk_flush(cur_q.persist_ok, key_q[vic_q], rd_q.pending);
        cnt_d   = cnt_q - CW'(1);
        state_d = S_DSEL;
        if (cur_q.persist_ok) begin
          mem_we        = 1'b1;
          wdata.pending = '0;
          rk_clean      = 1'b1;
        end else begin
          fail_d = 1'b1;
          if (rd_q.pending != '0) rk_mru = 1'b1;
          else rk_clean = 1'b1;
        end
      end

      S_RESP: begin
        rv_d    = 1'b1;
        res_d   = mk_resp(st_q);
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Entry flag, pin and recency updates for the target entry
  always_comb begin
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    dcnt_d   = dcnt_q;
    old_rank = rank_q[tgt];
    for (int j = 0; j < TABLE_ENTRIES; j++) begin
      rank_d[j] = rank_q[j];
      pin_d[j]  = pin_q[j];
    end
    used_d = used_q + CW'(used_inc) - CW'(used_dec);

    if ((rk_clean || rk_mru) && dirty_q[tgt]) begin
      // Close the gap left by the target
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        if (dirty_q[j] && rank_q[j] > old_rank) rank_d[j] = rank_q[j] - IW'(1);
      end
    end
    if (rk_clean && dirty_q[tgt]) begin
      dirty_d[tgt] = 1'b0;
      rank_d[tgt]  = '0;
      dcnt_d       = dcnt_q - CW'(1);
    end
    if (rk_mru) begin
      if (dirty_q[tgt]) begin
        rank_d[tgt] = IW'(dcnt_q - CW'(1));
      end else begin
        rank_d[tgt]  = IW'(dcnt_q);
        dirty_d[tgt] = 1'b1;
        dcnt_d       = dcnt_q + CW'(1);
      end
    end

    if (pin_inc && pin_q[tgt] != PIN_MAX) pin_d[tgt] = pin_q[tgt] + 16'd1;
    if (pin_dec && pin_q[tgt] != '0) pin_d[tgt] = pin_q[tgt] - 16'd1;
    if (pin_set1) pin_d[tgt] = 16'd1;

    if (v_set) valid_d[tgt] = 1'b1;
    if (v_clr) valid_d[tgt] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      vic_q   <= '0;
      r_q     <= '0;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
      st_q    <= ST_OK;
      used_q  <= '0;
      dcnt_q  <= '0;
      cap_q   <= 6'd32;
      rv_q    <= 1'b0;
      valid_q <= '0;
      dirty_q <= '0;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        pin_q[j]  <= '0;
        rank_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      vic_q   <= vic_d;
      r_q     <= r_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      st_q    <= st_d;
      used_q  <= used_d;
      dcnt_q  <= dcnt_d;
      rv_q    <= rv_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        pin_q[j]  <= pin_d[j];
        rank_q[j] <= rank_d[j];
      end
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // Payload registers: command word, result word, keys
  always_ff @(posedge clk_i) begin
    if (start && !busy) cur_q <= cmd_i;
    res_q <= res_d;
    if (key_we) key_q[tgt] <= cur_q.key_id;
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[tgt] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // The final word of a command always lands back in idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && res_q.last) |-> (state_q == S_IDLE))
    else $error("last word while sequencer still active");

  // Dirty count tracks the dirty flags
  a_dcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q == CW'($countones(dirty_q)))
    else $error("dirty count out of step");

  // Fill count tracks the valid flags
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CW'($countones(valid_q)))
    else $error("used count out of step");

  // Only valid entries may be dirty
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ~valid_q) == '0)
    else $error("dirty flag on free entry");

endmodule

// ----- dv/pinned_writeback_counter_cache_test.sv -----
`timescale 1ns / 1ps
// Self-checking test for the pinned write-back counter cache.
// Depends on pwcc_pkg and pinned_writeback_counter_cache; models the table in
// place and checks every result word against the predicted ones.
module pinned_writeback_counter_cache_test;
  import pwcc_pkg::*;

  localparam int NSLOT = 32;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  cmd_word_t cmd_i = '0;
  logic      res_valid_o;
  res_word_t res_o;
  logic       cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;

  pinned_writeback_counter_cache #(.TABLE_ENTRIES(NSLOT)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the table, updated as each command word is accepted.
  logic        slot_valid [NSLOT];
  logic [63:0] slot_key   [NSLOT];
  logic [63:0] slot_count [NSLOT];
  logic [63:0] slot_delta [NSLOT];
  logic [63:0] slot_stamp [NSLOT];
  logic        slot_dirty [NSLOT];
  logic [15:0] slot_pins  [NSLOT];
  int          slot_rank  [NSLOT];
  int          slots_used;
  logic [5:0]  capacity;

  res_word_t expected_words [$];
  int        mismatches;
  logic [63:0] key_pool [16];

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------
  task automatic expect_word(logic kind, logic [1:0] st, logic [63:0] fid,
                             logic [63:0] fdelta, logic [63:0] cnt_before,
                             logic [63:0] after, logic [63:0] mt, logic [63:0] ct,
                             logic fin);
    res_word_t r;
    r.kind = kind; r.status = st; r.flush_id = fid; r.flush_delta = fdelta;
    r.count_before = cnt_before; r.count_after = after; r.mtime_out = mt;
    r.ctime_out = ct; r.last = fin;
    expected_words.push_back(r);
  endtask

  task automatic respond(logic [1:0] st);
    expect_word(KIND_RESP, st, '0, '0, '0, '0, '0, '0, 1'b1);
  endtask

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int dirty_count();
    int d;
    d = 0;
    for (int i = 0; i < NSLOT; i++) if (slot_dirty[i]) d++;
    return d;
  endfunction

  // Pull every dirty rank above r down by one.
  task automatic close_rank_gap(int r);
    for (int j = 0; j < NSLOT; j++)
      if (slot_dirty[j] && slot_rank[j] > r) slot_rank[j]--;
  endtask

  task automatic clean_slot(int i);
    if (slot_dirty[i]) begin
      slot_dirty[i] = 1'b0;
      close_rank_gap(slot_rank[i]);
      slot_rank[i] = 0;
    end
  endtask

  task automatic touch_newest(int i);
    if (slot_dirty[i]) begin
      close_rank_gap(slot_rank[i]);
      slot_rank[i] = dirty_count() - 1;
    end else begin
      slot_rank[i] = dirty_count();
      slot_dirty[i] = 1'b1;
    end
  endtask

  task automatic drop_pin(int i);
    if (slot_pins[i] != 0) slot_pins[i]--;
  endtask

  function automatic int oldest_dirty_free();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot_dirty[i] && slot_pins[i] == 0 &&
          (best < 0 || slot_rank[i] < slot_rank[best])) best = i;
    return best;
  endfunction

  task automatic predict_prepare(cmd_word_t w);
    int i, v, cap;
    logic [63:0] delta;
    logic ok;
    i = lookup(w.key_id);
    if (i >= 0) begin
      if (w.seed_value > slot_count[i]) slot_count[i] = w.seed_value;
      if (slot_pins[i] != PIN_MAX) slot_pins[i]++;
      respond(ST_OK);
      return;
    end
    cap = (capacity < 4) ? 4 : (capacity > NSLOT) ? NSLOT : capacity;
    while (slots_used >= cap) begin
      // Evict a clean idle slot first, lowest index wins.
      v = -1;
      for (int j = 0; j < NSLOT; j++)
        if (v < 0 && slot_valid[j] && !slot_dirty[j] && slot_pins[j] == 0) v = j;
      if (v >= 0) begin
        slot_valid[v] = 1'b0;
        slots_used--;
        continue;
      end
      v = oldest_dirty_free();
      if (v < 0) begin
        respond(ST_FAIL);
        return;
      end
      delta = slot_delta[v];
      clean_slot(v);
      slot_valid[v] = 1'b0;
      slots_used--;
      ok = 1'b1;
      if (delta != 0) begin
        expect_word(KIND_FLUSH, w.persist_ok ? ST_OK : ST_FAIL, slot_key[v], delta,
                    '0, '0, '0, '0, 1'b0);
        ok = w.persist_ok;
      end
      if (!ok) begin
        // Refused write-back: put the victim back as newest dirty.
        slot_valid[v] = 1'b1;
        slots_used++;
        touch_newest(v);
        respond(ST_FAIL);
        return;
      end
    end
    i = -1;
    for (int j = 0; j < NSLOT; j++) if (i < 0 && !slot_valid[j]) i = j;
    if (i < 0) begin
      respond(ST_FAIL);
      return;
    end
    slot_valid[i] = 1'b1; slot_key[i] = w.key_id; slot_count[i] = w.seed_value;
    slot_delta[i] = '0; slot_stamp[i] = '0; slot_dirty[i] = 1'b0;
    slot_rank[i] = 0; slot_pins[i] = 16'd1;
    slots_used++;
    respond(ST_OK);
  endtask

  task automatic predict_flush_one(cmd_word_t w, output logic [1:0] st);
    int i;
    logic [63:0] delta;
    i = lookup(w.key_id);
    if (i < 0) begin
      st = ST_MISS;
      return;
    end
    if (!slot_dirty[i] || slot_delta[i] == 0) begin
      st = ST_OK;
      return;
    end
    delta = slot_delta[i];
    slot_delta[i] = '0;
    clean_slot(i);
    expect_word(KIND_FLUSH, w.persist_ok ? ST_OK : ST_FAIL, w.key_id, delta,
                '0, '0, '0, '0, 1'b0);
    if (w.persist_ok) begin
      st = ST_OK;
      return;
    end
    slot_delta[i] += delta;
    if (slot_delta[i] != 0) touch_newest(i);
    st = ST_FAIL;
  endtask

  task automatic predict_drain(cmd_word_t w);
    int order [NSLOT];
    logic [63:0] deltas [NSLOT];
    int d, cnt, e;
    logic found;
    d = dirty_count();
    cnt = 0;
    for (int r = 0; r < d; r++) begin
      found = 1'b0;
      for (int j = 0; j < NSLOT; j++)
        if (!found && slot_dirty[j] && slot_rank[j] == r) begin
          order[cnt] = j;
          cnt++;
          found = 1'b1;
        end
    end
    for (int k = 0; k < cnt; k++) begin
      deltas[k] = slot_delta[order[k]];
      slot_delta[order[k]] = '0;
      clean_slot(order[k]);
    end
    for (int k = 0; k < cnt; k++) begin
      e = order[k];
      expect_word(KIND_FLUSH, w.persist_ok ? ST_OK : ST_FAIL, slot_key[e], deltas[k],
                  '0, '0, '0, '0, 1'b0);
      if (!w.persist_ok) begin
        slot_delta[e] += deltas[k];
        if (slot_delta[e] != 0) touch_newest(e);
      end
    end
    respond((!w.persist_ok && cnt > 0) ? ST_FAIL : ST_OK);
  endtask

  task automatic predict_command(cmd_word_t w);
    int i;
    logic [1:0] st;
    logic [63:0] cnt, mt, ct;
    i = lookup(w.key_id);
    case (w.cmd)
      CMD_PREPARE: predict_prepare(w);
      CMD_COMMIT: begin
        if (i < 0) begin
          respond(ST_MISS);
        end else begin
          slot_count[i]++;
          slot_delta[i]++;
          if (w.now_stamp > slot_stamp[i]) slot_stamp[i] = w.now_stamp;
          touch_newest(i);
          drop_pin(i);
          expect_word(KIND_RESP, ST_OK, '0, '0, slot_count[i] - 64'd1, slot_count[i],
                      '0, '0, 1'b1);
        end
      end
      CMD_ABORT: begin
        if (i < 0) begin
          respond(ST_MISS);
        end else begin
          drop_pin(i);
          if (slot_pins[i] == 0 && !slot_dirty[i] && slot_delta[i] == 0) begin
            slot_valid[i] = 1'b0;
            slots_used--;
          end
          respond(ST_OK);
        end
      end
      CMD_SYNC: begin
        if (i < 0) begin
          respond(ST_MISS);
        end else begin
          slot_count[i]++;
          if (w.now_stamp > slot_stamp[i]) slot_stamp[i] = w.now_stamp;
          respond(ST_OK);
        end
      end
      CMD_OVERLAY: begin
        cnt = w.seed_value; mt = w.mtime_in; ct = w.ctime_in;
        if (i >= 0) begin
          if (slot_count[i] > cnt) cnt = slot_count[i];
          if (slot_stamp[i] > mt) mt = slot_stamp[i];
          if (slot_stamp[i] > ct) ct = slot_stamp[i];
        end
        expect_word(KIND_RESP, (i < 0) ? ST_MISS : ST_OK, '0, '0, '0, cnt, mt, ct,
                    1'b1);
      end
      CMD_FLUSH: begin
        predict_flush_one(w, st);
        respond(st);
      end
      CMD_FLUSHDROP: begin
        predict_flush_one(w, st);
        if (st != ST_FAIL) begin
          i = lookup(w.key_id);
          if (i >= 0 && slot_pins[i] == 0 && slot_delta[i] == 0) begin
            clean_slot(i);
            slot_valid[i] = 1'b0;
            slots_used--;
          end
          st = ST_OK;
        end
        respond(st);
      end
      default: predict_drain(w);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so take every strobed word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_word_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", res_o);
      end else begin
        want = expected_words.pop_front();
        if (res_o.kind !== want.kind || res_o.status !== want.status ||
            res_o.flush_id !== want.flush_id || res_o.flush_delta !== want.flush_delta ||
            res_o.count_before !== want.count_before ||
            res_o.count_after !== want.count_after ||
            res_o.mtime_out !== want.mtime_out || res_o.ctime_out !== want.ctime_out ||
            res_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                     $realtime, want, res_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Lower start for a gap of idle cycles, then present the word until taken.
  // Called and returns at a falling edge.
  task automatic send_word(cmd_word_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_command(w);
    @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [2:0] c, logic [63:0] k, logic [63:0] seed,
                          logic [63:0] now, logic ok, int gap);
    cmd_word_t w;
    w.cmd = c; w.key_id = k; w.seed_value = seed; w.now_stamp = now;
    w.mtime_in = rand64(); w.ctime_in = rand64(); w.persist_ok = ok;
    send_word(w, gap);
  endtask

  // Lower start, let every expected word arrive and the block settle, then write.
  task automatic set_capacity(logic [5:0] value);
    start <= 1'b0;
    @(negedge clk_i);
    wait (expected_words.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = value;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extremes of keys and counters, every command, wrap of the counter, overlay
  // pass-through on a miss and flushes of clean and absent entries.
  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_cmd(CMD_COMMIT,    ones, 0, 0, 1, 0);     // commit miss
    send_cmd(CMD_OVERLAY,   ones, ones, 0, 1, 0);  // overlay miss passes inputs
    send_cmd(CMD_PREPARE,   ones, ones, 0, 1, 0);
    send_cmd(CMD_PREPARE,   '0, '0, 0, 1, 1);
    send_cmd(CMD_COMMIT,    ones, 0, ones, 1, 0);  // counter wraps to zero
    send_cmd(CMD_SYNC,      '0, 0, 5, 1, 0);
    send_cmd(CMD_SYNC,      64'd77, 0, 5, 1, 0);   // sync miss
    send_cmd(CMD_OVERLAY,   ones, 0, 0, 1, 0);
    send_cmd(CMD_FLUSH,     '0, 0, 0, 1, 0);       // clean entry, no request
    send_cmd(CMD_FLUSH,     64'd77, 0, 0, 1, 0);   // flush miss
    send_cmd(CMD_FLUSH,     ones, 0, 0, 0, 0);     // refused, delta restored
    send_cmd(CMD_FLUSHDROP, ones, 0, 0, 0, 0);     // refused drop keeps entry
    send_cmd(CMD_FLUSHDROP, ones, 0, 0, 1, 2);
    send_cmd(CMD_FLUSHDROP, 64'd77, 0, 0, 1, 0);   // drop of a miss is ok
    send_cmd(CMD_ABORT,     '0, 0, 0, 1, 0);       // frees a clean idle entry
    send_cmd(CMD_ABORT,     '0, 0, 0, 1, 0);       // abort miss
    send_cmd(CMD_ABORT,     '0, 0, 0, 1, 0);       // second abort miss
    send_cmd(CMD_DRAIN,     '0, 0, 0, 1, 0);       // empty drain
  endtask

  // Fill a small table with dirty unpinned entries and force write-back evictions,
  // refused and accepted, and finally a table of pinned entries with no victim.
  task automatic test_eviction();
    for (int k = 0; k < 4; k++) begin
      send_cmd(CMD_PREPARE, key_pool[k], k, 0, 1, 0);
      send_cmd(CMD_COMMIT, key_pool[k], 0, 100 + k, 1, 0);
    end
    send_cmd(CMD_PREPARE, key_pool[4], 0, 0, 0, 0);  // refused victim reinserted
    send_cmd(CMD_PREPARE, key_pool[4], 0, 0, 1, 1);  // victim written back
    send_cmd(CMD_DRAIN, '0, 0, 0, 0, 0);             // drain refused
    send_cmd(CMD_DRAIN, '0, 0, 0, 1, 0);
    for (int k = 5; k < 9; k++) send_cmd(CMD_PREPARE, key_pool[k], 0, 0, 1, 0);
    send_cmd(CMD_PREPARE, key_pool[9], 0, 0, 1, 0);  // all pinned: fallback
  endtask

  // Pin one entry several times, then release it past zero.
  task automatic test_pin_count();
    for (int n = 0; n < 6; n++)
      send_cmd(CMD_PREPARE, key_pool[15], 64'(n), 0, 1, 0);
    send_cmd(CMD_COMMIT, key_pool[15], 0, 1, 1, 0);
    for (int n = 0; n < 7; n++)
      send_cmd(CMD_ABORT, key_pool[15], 0, 0, 1, pick_gap());
  endtask

  // Mostly prepare/commit traffic on a small key set, with misses and noise.
  task automatic test_random(int items);
    int r;
    logic [2:0] c;
    logic [63:0] k;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      c = (r < 30) ? CMD_PREPARE : (r < 55) ? CMD_COMMIT : (r < 62) ? CMD_ABORT :
          (r < 70) ? CMD_SYNC : (r < 78) ? CMD_OVERLAY : (r < 87) ? CMD_FLUSH :
          (r < 95) ? CMD_FLUSHDROP : CMD_DRAIN;
      k = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 11)];
      send_cmd(c, k, ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 50)),
               rand64(), $urandom_range(0, 3) != 0, pick_gap());
    end
  endtask

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mismatches = 0;
    slots_used = 0;
    capacity = 6'd32;
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0; slot_key[i] = '0; slot_count[i] = '0;
      slot_delta[i] = '0; slot_stamp[i] = '0; slot_dirty[i] = 1'b0;
      slot_pins[i] = '0; slot_rank[i] = 0;
    end
    for (int i = 0; i < 16; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    set_capacity(6'd4);
    test_eviction();
    set_capacity(6'd0);       // below the floor, acts as 4
    test_random(60);
    set_capacity(6'd63);      // above the table, acts as full size
    test_random(60);
    set_capacity(6'd32);
    test_pin_count();
    set_capacity(6'($urandom_range(5, 31)));
    test_random(60);
    set_capacity(6'd4);
    test_random(60);

    start <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
